/* rtl/psrbu_pkg.sv */
// ----------------------------------------------------------------------------
// psrbu_pkg
// Shared types and constants of the belief update and observation sampler.
// ----------------------------------------------------------------------------
package psrbu_pkg;

   localparam int MAX_DIM_DEF     = 16;
   localparam int NUM_ACTIONS_DEF = 4;
   localparam int NUM_OBS         = 4;

   localparam logic [1:0] OBS_LAST = 2'd3;
   localparam logic [4:0] DIM_RESET = 5'd16;

   // request codes
   localparam logic [2:0] REQ_WR_MAT  = 3'd0;
   localparam logic [2:0] REQ_WR_NORM = 3'd1;
   localparam logic [2:0] REQ_WR_BEL  = 3'd2;
   localparam logic [2:0] REQ_SAMPLE  = 3'd3;
   localparam logic [2:0] REQ_UPDATE  = 3'd4;

   typedef struct packed {
      logic [2:0]         req_type;
      logic [1:0]         action;
      logic [1:0]         observation;
      logic [3:0]         row;
      logic [3:0]         col;
      logic signed [31:0] value;
      logic [23:0]        threshold;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         obs_out;
      logic               status;
      logic signed [31:0] norm_value;
   } rsp_item_type;

   typedef struct packed {
      logic latch_req;
      logic clr_res;
      logic wr_exec;
      logic mac_issue;
      logic y_capture;
      logic n_mul;
      logic n_acc;
      logic clr_nacc;
      logic n_capture;
      logic run_clr;
      logic run_add;
      logic set_obs;
      logic set_status;
      logic set_norm;
      logic div_start;
      logic bv_wr;
   } cmd_type;

   typedef struct packed {
      logic [2:0] req_code;
      logic       found;
      logic       n_zero;
      logic       div_done;
   } sts_type;

endpackage

/* rtl/psrbu_ram.sv */
// ----------------------------------------------------------------------------
// psrbu_ram
// Single-port RAM, registered read.
// ----------------------------------------------------------------------------
module psrbu_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    addr,
   input  logic [WIDTH-1:0] wdata,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata <= mem[addr];
   end

endmodule

/* rtl/psrbu_div.sv */
// ----------------------------------------------------------------------------
// psrbu_div
// Restoring divider, one quotient bit per cycle: (num * 2^24) / den,
// truncated toward zero, saturated to 32 bits. den must be non-zero.
// ----------------------------------------------------------------------------
module psrbu_div (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [31:0] num,
   input  logic signed [31:0] den,
   output logic               done,
   output logic signed [31:0] quot
);

   localparam int QW = 56;

   logic            busy_ff, busy_in;
   logic            done_ff, done_in;
   logic [5:0]      cnt_ff, cnt_in;
   logic [32:0]     rem_ff, rem_in;
   logic [QW-1:0]   dvd_ff, dvd_in;
   logic [QW-1:0]   q_ff, q_in;
   logic [31:0]     den_ff, den_in;
   logic            neg_ff, neg_in;
   logic [32:0]     rem_sh;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      q_in    = q_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      rem_sh  = {rem_ff[31:0], dvd_ff[QW-1]};
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         q_in    = '0;
         neg_in  = num[31] ^ den[31];
         dvd_in  = {(num[31] ? 32'(-num) : 32'(num)), 24'd0};
         den_in  = den[31] ? 32'(-den) : 32'(den);
      end else if (busy_ff) begin
         if (rem_sh >= {1'b0, den_ff}) begin
            rem_in = rem_sh - {1'b0, den_ff};
            q_in   = {q_ff[QW-2:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            q_in   = {q_ff[QW-2:0], 1'b0};
         end
         dvd_in = {dvd_ff[QW-2:0], 1'b0};
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'(QW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      dvd_ff <= dvd_in;
      q_ff   <= q_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      if (!neg_ff) begin
         quot = (q_ff > QW'(32'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(q_ff[31:0]);
      end else begin
         quot = (q_ff > QW'(32'h8000_0000)) ? 32'sh8000_0000 : $signed(32'(-q_ff[31:0]));
      end
   end

   assign done = done_ff;

endmodule

/* rtl/psrbu_dp.sv */
// ----------------------------------------------------------------------------
// psrbu_dp
// Datapath: operator, normalizer, belief and y stores, shared multiplier,
// accumulators, divider and result registers.
// ----------------------------------------------------------------------------
module psrbu_dp #(
   parameter int MAX_DIM     = psrbu_pkg::MAX_DIM_DEF,
   parameter int NUM_ACTIONS = psrbu_pkg::NUM_ACTIONS_DEF,
   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int DW = $clog2(MAX_DIM + 1)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  psrbu_pkg::req_item_type req_item,
   input  logic                   csr_valid,
   input  logic [4:0]             csr_data,
   input  psrbu_pkg::cmd_type     cmd,
   input  logic [IW-1:0]          i_idx,
   input  logic [IW-1:0]          j_idx,
   input  logic [1:0]             o_idx,
   output psrbu_pkg::sts_type     sts,
   output logic [DW-1:0]          dim,
   output psrbu_pkg::rsp_item_type rsp_item
);

   localparam int MD2 = MAX_DIM * MAX_DIM;
   localparam int OPD = NUM_ACTIONS * psrbu_pkg::NUM_OBS * MD2;
   localparam int OPW = $clog2(OPD);
   localparam int AW  = 41 + IW;

   function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] v);
      if (v[AW-1:31] == '0 || v[AW-1:31] == '1) begin
         return v[31:0];
      end else if (v[AW-1]) begin
         return 32'sh8000_0000;
      end else begin
         return 32'sh7FFF_FFFF;
      end
   endfunction

   psrbu_pkg::req_item_type req_ff;
   logic [4:0]          dim_ff;
   logic                v1_ff, v2_ff;
   logic signed [39:0]  prod_ff;
   logic signed [AW-1:0] acc_ff, nacc_ff;
   logic signed [31:0]  y_ff, n_ff;
   logic signed [33:0]  run_ff, run_sum, thr_ext;
   logic [1:0]          obs_ff;
   logic                status_ff;
   logic signed [31:0]  norm_ff;

   logic signed [31:0]  mul_a, mul_b;
   logic signed [63:0]  mul_p;
   logic [31:0]         op_rdata, nv_rdata, bv_rdata, y_rdata;
   logic [OPW-1:0]      op_addr;
   logic                op_we, nv_we, bv_we, row_ok, col_ok;
   logic [IW-1:0]       nv_addr, bv_addr;
   logic [31:0]         bv_wdata;
   logic                div_done;
   logic signed [31:0]  div_q;

   // operator store addressing, action folded into range
   always_comb begin
      int a;
      int g;
      a = int'(req_ff.action);
      for (int k = 0; k < 3; k++) begin
         if (a >= NUM_ACTIONS) begin
            a = a - NUM_ACTIONS;
         end
      end
      if (cmd.wr_exec || req_ff.req_type != psrbu_pkg::REQ_SAMPLE) begin
         g = a * psrbu_pkg::NUM_OBS + int'(req_ff.observation);
      end else begin
         g = a * psrbu_pkg::NUM_OBS + int'(o_idx);
      end
      if (cmd.wr_exec) begin
         op_addr = OPW'(g * MD2 + int'(req_ff.row) * MAX_DIM + int'(req_ff.col));
      end else begin
         op_addr = OPW'(g * MD2 + int'(i_idx) * MAX_DIM + int'(j_idx));
      end
   end

   assign row_ok = int'(req_ff.row) < MAX_DIM;
   assign col_ok = int'(req_ff.col) < MAX_DIM;
   assign op_we  = cmd.wr_exec && req_ff.req_type == psrbu_pkg::REQ_WR_MAT && row_ok && col_ok;
   assign nv_we  = cmd.wr_exec && req_ff.req_type == psrbu_pkg::REQ_WR_NORM && row_ok;
   assign bv_we  = (cmd.wr_exec && req_ff.req_type == psrbu_pkg::REQ_WR_BEL && row_ok)
                   || cmd.bv_wr;
   assign nv_addr = nv_we ? IW'(req_ff.row) : i_idx;
   assign bv_addr = cmd.bv_wr ? i_idx : (cmd.wr_exec ? IW'(req_ff.row) : j_idx);
   assign bv_wdata = cmd.bv_wr ? div_q : req_ff.value;

   psrbu_ram #(.WIDTH(32), .DEPTH(OPD)) u_op_ram (
      .clock(clock), .we(op_we), .addr(op_addr), .wdata(req_ff.value), .rdata(op_rdata)
   );

   psrbu_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_nv_ram (
      .clock(clock), .we(nv_we), .addr(nv_addr), .wdata(req_ff.value), .rdata(nv_rdata)
   );

   psrbu_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_bv_ram (
      .clock(clock), .we(bv_we), .addr(bv_addr), .wdata(bv_wdata), .rdata(bv_rdata)
   );

   psrbu_ram #(.WIDTH(32), .DEPTH(MAX_DIM)) u_y_ram (
      .clock(clock), .we(cmd.n_mul), .addr(i_idx), .wdata(y_ff), .rdata(y_rdata)
   );

   psrbu_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start),
      .num($signed(y_rdata)), .den(n_ff), .done(div_done), .quot(div_q)
   );

   // shared multiplier, product floored to Q8.24
   assign mul_a = cmd.n_mul ? $signed(nv_rdata) : $signed(op_rdata);
   assign mul_b = cmd.n_mul ? y_ff : $signed(bv_rdata);
   assign mul_p = mul_a * mul_b;

   assign run_sum = run_ff + 34'(n_ff);
   assign thr_ext = $signed({10'd0, req_ff.threshold});

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_ff <= psrbu_pkg::DIM_RESET;
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            dim_ff <= csr_data;
         end
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff;
      end
      prod_ff <= mul_p[63:24];
      if (cmd.latch_req) begin
         req_ff <= req_item;
      end
      if (cmd.latch_req || cmd.y_capture) begin
         acc_ff <= '0;
      end else if (v2_ff) begin
         acc_ff <= acc_ff + AW'(prod_ff);
      end
      if (cmd.y_capture) begin
         y_ff <= sat32(acc_ff);
      end
      if (cmd.clr_nacc) begin
         nacc_ff <= '0;
      end else if (cmd.n_acc) begin
         nacc_ff <= nacc_ff + AW'(prod_ff);
      end
      if (cmd.n_capture) begin
         n_ff <= sat32(nacc_ff);
      end
      if (cmd.run_clr) begin
         run_ff <= '0;
      end else if (cmd.run_add) begin
         run_ff <= run_sum;
      end
      if (cmd.clr_res) begin
         obs_ff    <= '0;
         status_ff <= 1'b0;
         norm_ff   <= '0;
      end else begin
         if (cmd.set_obs)    obs_ff    <= o_idx;
         if (cmd.set_status) status_ff <= 1'b1;
         if (cmd.set_norm)   norm_ff   <= n_ff;
      end
   end

   // compared as integers so that a MAX_DIM of 32 or more never clamps
   assign dim = (int'(dim_ff) > MAX_DIM) ? DW'(MAX_DIM) : DW'(dim_ff);

   assign sts.req_code = req_ff.req_type;
   assign sts.found    = run_sum > thr_ext;
   assign sts.n_zero   = n_ff == '0;
   assign sts.div_done = div_done;

   assign rsp_item.obs_out    = obs_ff;
   assign rsp_item.status     = status_ff;
   assign rsp_item.norm_value = norm_ff;

endmodule

/* rtl/psrbu_ctrl.sv */
// ----------------------------------------------------------------------------
// psrbu_ctrl
// Sequencer: walks rows and columns of the operator products, up to four
// observations of a sample and the per-entry divisions of an update.
// ----------------------------------------------------------------------------
module psrbu_ctrl #(
   parameter int MAX_DIM = psrbu_pkg::MAX_DIM_DEF,
   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1,
   localparam int DW = $clog2(MAX_DIM + 1)
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output logic               rsp_strobe,
   input  psrbu_pkg::sts_type sts,
   input  logic [DW-1:0]      dim,
   output psrbu_pkg::cmd_type cmd,
   output logic [IW-1:0]      i_idx,
   output logic [IW-1:0]      j_idx,
   output logic [1:0]         o_idx
);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DEC   = 4'd1;
   localparam logic [3:0] S_WR    = 4'd2;
   localparam logic [3:0] S_ROW   = 4'd3;
   localparam logic [3:0] S_D1    = 4'd4;
   localparam logic [3:0] S_D2    = 4'd5;
   localparam logic [3:0] S_YS    = 4'd6;
   localparam logic [3:0] S_NMUL  = 4'd7;
   localparam logic [3:0] S_NACC  = 4'd8;
   localparam logic [3:0] S_NEND  = 4'd9;
   localparam logic [3:0] S_EVAL  = 4'd10;
   localparam logic [3:0] S_YRD   = 4'd11;
   localparam logic [3:0] S_DST   = 4'd12;
   localparam logic [3:0] S_DWAIT = 4'd13;
   localparam logic [3:0] S_DONE  = 4'd14;

   logic [3:0]    state_ff, state_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in;
   logic [1:0]    o_ff, o_in;
   logic          i_last, j_last;

   assign i_last = (i_ff + DW'(1)) == dim;
   assign j_last = (j_ff + DW'(1)) == dim;

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      o_in     = o_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               cmd.latch_req = 1'b1;
               state_in      = S_DEC;
            end
         end
         S_DEC: begin
            cmd.clr_res  = 1'b1;
            cmd.clr_nacc = 1'b1;
            cmd.run_clr  = 1'b1;
            i_in = '0;
            j_in = '0;
            o_in = '0;
            priority case (sts.req_code)
               psrbu_pkg::REQ_WR_MAT, psrbu_pkg::REQ_WR_NORM,
               psrbu_pkg::REQ_WR_BEL: state_in = S_WR;
               psrbu_pkg::REQ_SAMPLE, psrbu_pkg::REQ_UPDATE:
                  state_in = (dim == '0) ? S_NEND : S_ROW;
               default: state_in = S_DONE;
            endcase
         end
         S_WR: begin
            cmd.wr_exec = 1'b1;
            state_in    = S_DONE;
         end
         S_ROW: begin
            cmd.mac_issue = 1'b1;
            if (j_last) begin
               j_in     = '0;
               state_in = S_D1;
            end else begin
               j_in = j_ff + DW'(1);
            end
         end
         S_D1: state_in = S_D2;
         S_D2: state_in = S_YS;
         S_YS: begin
            cmd.y_capture = 1'b1;
            state_in      = S_NMUL;
         end
         S_NMUL: begin
            cmd.n_mul = 1'b1;
            state_in  = S_NACC;
         end
         S_NACC: begin
            cmd.n_acc = 1'b1;
            if (i_last) begin
               i_in     = '0;
               state_in = S_NEND;
            end else begin
               i_in     = i_ff + DW'(1);
               state_in = S_ROW;
            end
         end
         S_NEND: begin
            cmd.n_capture = 1'b1;
            state_in      = S_EVAL;
         end
         S_EVAL: begin
            if (sts.req_code == psrbu_pkg::REQ_SAMPLE) begin
               cmd.run_add = 1'b1;
               if (sts.found) begin
                  cmd.set_obs = 1'b1;
                  state_in    = S_DONE;
               end else if (o_ff == psrbu_pkg::OBS_LAST) begin
                  state_in = S_DONE;
               end else begin
                  o_in         = o_ff + 2'd1;
                  i_in         = '0;
                  cmd.clr_nacc = 1'b1;
                  state_in     = (dim == '0) ? S_NEND : S_ROW;
               end
            end else if (sts.n_zero) begin
               cmd.set_status = 1'b1;
               state_in       = S_DONE;
            end else begin
               cmd.set_norm = 1'b1;
               i_in         = '0;
               state_in     = S_YRD;
            end
         end
         S_YRD: state_in = S_DST;
         S_DST: begin
            cmd.div_start = 1'b1;
            state_in      = S_DWAIT;
         end
         S_DWAIT: begin
            if (sts.div_done) begin
               cmd.bv_wr = 1'b1;
               if (i_last) begin
                  state_in = S_DONE;
               end else begin
                  i_in     = i_ff + DW'(1);
                  state_in = S_YRD;
               end
            end
         end
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         o_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         o_ff     <= o_in;
      end
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = state_ff == S_DONE;
   assign i_idx      = i_ff[IW-1:0];
   assign j_idx      = j_ff[IW-1:0];
   assign o_idx      = o_ff;

endmodule

/* rtl/psr_belief_update_sampler.sv */
// ----------------------------------------------------------------------------
// psr_belief_update_sampler
// Predictive-state belief update and observation sampler, Q8.24 fixed point.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays high
// until its single result has been shown. Every request gives exactly one
// result, on rsp_item for one cycle with rsp_strobe high. The receiver cannot
// stall: capture it in that cycle. Configuration (active_dim) is written on
// csr_valid, ready is always high; write it only while the block is idle.
//
// Work per request, with d = min(active_dim, MAX_DIM):
//  - word writes: a single store write; unused codes: straight to the result
//  - one matrix-vector pass with its normaliser is paced by the single
//    shared multiplier, which reads the operator RAM one word a cycle
//    within a row (three-stage read, multiply, accumulate pipeline)
//  - sample: up to four passes
//  - update: one pass plus, unless the normaliser is zero, d divisions one
//    after another in the one bit-per-cycle divider
// The stores are not cleared after reset; an entry must be written before use.
// ----------------------------------------------------------------------------
module psr_belief_update_sampler #(
   parameter int MAX_DIM     = psrbu_pkg::MAX_DIM_DEF,
   parameter int NUM_ACTIONS = psrbu_pkg::NUM_ACTIONS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  psrbu_pkg::req_item_type  req_item,
   output logic                    rsp_strobe,
   output psrbu_pkg::rsp_item_type  rsp_item,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [4:0]              csr_data
);

   localparam int IW = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int DW = $clog2(MAX_DIM + 1);

   psrbu_pkg::cmd_type cmd;
   psrbu_pkg::sts_type sts;
   logic [DW-1:0]      dim;
   logic [IW-1:0]      i_idx, j_idx;
   logic [1:0]         o_idx;

   // register transfer always accepted
   assign csr_ready = 1'b1;

   psrbu_ctrl #(.MAX_DIM(MAX_DIM)) u_ctrl (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .rsp_strobe(rsp_strobe), .sts(sts), .dim(dim), .cmd(cmd),
      .i_idx(i_idx), .j_idx(j_idx), .o_idx(o_idx)
   );

   psrbu_dp #(.MAX_DIM(MAX_DIM), .NUM_ACTIONS(NUM_ACTIONS)) u_dp (
      .clock(clock), .reset(reset), .req_item(req_item),
      .csr_valid(csr_valid), .csr_data(csr_data), .cmd(cmd),
      .i_idx(i_idx), .j_idx(j_idx), .o_idx(o_idx), .sts(sts), .dim(dim),
      .rsp_item(rsp_item)
   );

endmodule

/* verif/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the belief update and observation sampler: fills
// the store words that later requests read, walks a directed table, then runs
// random phases at small active_dim settings with an in-bench predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic                    busy;
   psrbu_pkg::req_item_type req_item = '0;
   logic                    rsp_strobe;
   psrbu_pkg::rsp_item_type rsp_item;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   logic [4:0]              csr_data = '0;

   psr_belief_update_sampler dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_strobe(rsp_strobe), .rsp_item(rsp_item),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // generous ceiling for the whole run
   initial begin
      #40000000;
      $display("[psr_belief_update_sampler] ERROR");
      $finish;
   end

   // ---------------------------------------------------------------- predictor
   logic signed [31:0] op_mem [0:4095];
   logic signed [31:0] nrm_mem [0:15];
   logic signed [31:0] bel_mem [0:15];
   logic signed [31:0] y_vec [0:15];
   logic [4:0]         dim_reg = psrbu_pkg::DIM_RESET;

   psrbu_pkg::rsp_item_type result_q [$];
   int error_count = 0;
   int n_results = 0, n_samples = 0, n_updates = 0, n_zero_norm = 0;

   function automatic logic signed [31:0] sat32(input longint v);
      if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return v[31:0];
   endfunction

   // exact product, floored back to Q8.24
   function automatic longint mul_q(input logic signed [31:0] a,
                                    input logic signed [31:0] b);
      longint p;
      p = longint'(a) * longint'(b);
      return p >>> 24;
   endfunction

   // y = sat(B[g].b) then binf.y, over the first d entries
   task automatic op_norm(input int g, input int d, output logic signed [31:0] n);
      longint acc;
      for (int i = 0; i < d; i++) begin
         acc = 0;
         for (int j = 0; j < d; j++)
            acc += mul_q(op_mem[(g * 16 + i) * 16 + j], bel_mem[j]);
         y_vec[i] = sat32(acc);
      end
      acc = 0;
      for (int i = 0; i < d; i++) acc += mul_q(nrm_mem[i], y_vec[i]);
      n = sat32(acc);
   endtask

   task automatic predict_rsp(input psrbu_pkg::req_item_type it,
                              output psrbu_pkg::rsp_item_type r);
      int d;
      int g;
      longint run;
      logic signed [31:0] n;
      r = '0;
      d = (dim_reg > 16) ? 16 : dim_reg;
      case (it.req_type)
         psrbu_pkg::REQ_WR_MAT: op_mem[((it.action * 4 + it.observation) * 16 + it.row) * 16
                                       + it.col] = it.value;
         psrbu_pkg::REQ_WR_NORM: nrm_mem[it.row] = it.value;
         psrbu_pkg::REQ_WR_BEL: bel_mem[it.row] = it.value;
         psrbu_pkg::REQ_SAMPLE: begin
            run = 0;
            for (int o = 0; o < psrbu_pkg::NUM_OBS; o++) begin
               op_norm(it.action * 4 + o, d, n);
               run += longint'(n);
               if (run > longint'({8'd0, it.threshold})) begin
                  r.obs_out = o[1:0];
                  break;
               end
            end
         end
         psrbu_pkg::REQ_UPDATE: begin
            g = it.action * 4 + it.observation;
            op_norm(g, d, n);
            if (n == 0) r.status = 1'b1;
            else begin
               r.norm_value = n;
               for (int i = 0; i < d; i++)
                  bel_mem[i] = sat32((longint'(y_vec[i]) * 64'sd16777216) / longint'(n));
            end
         end
         default: ;
      endcase
   endtask

   // ---------------------------------------------------------------- checker
   always @(posedge clock) begin
      psrbu_pkg::rsp_item_type want;
      if (!reset && rsp_strobe) begin
         n_results++;
         if (result_q.size() == 0) begin
            $display("%0t: unexpected result %p", $time, rsp_item);
            error_count++;
         end else begin
            want = result_q.pop_front();
            if (rsp_item.obs_out !== want.obs_out) begin
               $display("%0t: obs_out exp %0d got %0d", $time, want.obs_out,
                        rsp_item.obs_out);
               error_count++;
            end
            if (rsp_item.status !== want.status) begin
               $display("%0t: status exp %0d got %0d", $time, want.status,
                        rsp_item.status);
               error_count++;
            end
            if (rsp_item.norm_value !== want.norm_value) begin
               $display("%0t: norm_value exp %h got %h", $time, want.norm_value,
                        rsp_item.norm_value);
               error_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- driving
   int burst_left = 0;

   // one request transfer; typed-in expectation overrides the predictor
   task automatic send_req(input psrbu_pkg::req_item_type it, input bit has_exp,
                           input psrbu_pkg::rsp_item_type ex);
      psrbu_pkg::rsp_item_type r;
      if (burst_left == 0) begin
         start = 1'b0;
         repeat ($urandom_range(0, 5)) @(negedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      start = 1'b1;
      req_item = it;
      do @(posedge clock); while (busy);
      predict_rsp(it, r);
      if (it.req_type == psrbu_pkg::REQ_SAMPLE) n_samples++;
      if (it.req_type == psrbu_pkg::REQ_UPDATE) begin
         n_updates++;
         if (r.status) n_zero_norm++;
      end
      if (has_exp) r = ex;
      result_q = {result_q, r};
      @(negedge clock);
   endtask

   // hold off until every expected result is back
   task automatic drain;
      start = 1'b0;
      while (result_q.size() != 0 || busy) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_dim(input logic [4:0] v);
      drain();
      csr_valid = 1'b1;
      csr_data = v;
      do @(posedge clock); while (!csr_ready);
      dim_reg = v;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   function automatic logic signed [31:0] rand_word;
      case ($urandom_range(0, 9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2, 3: return $urandom();
         default: return $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
      endcase
   endfunction

   function automatic psrbu_pkg::req_item_type rand_req;
      psrbu_pkg::req_item_type it;
      int pick;
      it.req_type = psrbu_pkg::REQ_WR_MAT;
      it.action = 2'($urandom_range(0, 3));
      it.observation = 2'($urandom_range(0, 3));
      it.row = 4'($urandom_range(0, 15));
      it.col = 4'($urandom_range(0, 15));
      it.value = rand_word();
      it.threshold = 24'($urandom_range(0, 24'hFFFFFF));
      pick = $urandom_range(0, 99);
      if (pick < 30) it.req_type = psrbu_pkg::REQ_WR_MAT;
      else if (pick < 40) begin
         it.req_type = psrbu_pkg::REQ_WR_NORM;
         if ($urandom_range(0, 3) == 0) it.value = '0;
      end else if (pick < 50) it.req_type = psrbu_pkg::REQ_WR_BEL;
      else if (pick < 72) it.req_type = psrbu_pkg::REQ_SAMPLE;
      else if (pick < 95) it.req_type = psrbu_pkg::REQ_UPDATE;
      else it.req_type = 3'($urandom_range(5, 7));
      return it;
   endfunction

   // ---------------------------------------------------------------- table
   typedef struct {
      logic [4:0]              dim;
      psrbu_pkg::req_item_type item;
      bit                      has_exp;
      psrbu_pkg::rsp_item_type exp;
   } stim_row_type;

   stim_row_type stim_tab [$];

   task automatic add_row(input logic [4:0] dim, input logic [2:0] code,
                          input logic [1:0] a, input logic [1:0] o,
                          input logic [3:0] r, input logic [3:0] c,
                          input logic [31:0] v, input logic [23:0] thr,
                          input bit has_exp, input psrbu_pkg::rsp_item_type ex);
      stim_row_type s;
      s.dim = dim;
      s.item = '{req_type:code, action:a, observation:o, row:r, col:c,
                 value:v, threshold:thr};
      s.has_exp = has_exp;
      s.exp = ex;
      stim_tab = {stim_tab, s};
   endtask

   initial begin
      psrbu_pkg::req_item_type it;
      psrbu_pkg::rsp_item_type zr;
      psrbu_pkg::rsp_item_type zn;
      logic [4:0] dim_list [4];
      zr = '0;
      zn = '{obs_out:2'd0, status:1'b1, norm_value:32'sd0};
      dim_list = '{5'd2, 5'd1, 5'd0, 5'd2};

      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // operator words that are read later: the whole of group zero for the
      // full-width updates, the first two rows and columns of every other group
      for (int k = 0; k < 4096; k++) begin
         if (k < 256 || (k[7:4] < 4'd2 && k[3:0] < 4'd2)) begin
            it = '0;
            it.req_type = psrbu_pkg::REQ_WR_MAT;
            {it.action, it.observation, it.row, it.col} = k[11:0];
            it.value = $signed($urandom_range(0, 32'h00FFFFFF)) - 32'sh00800000;
            send_req(it, 1'b0, zr);
         end
      end
      for (int k = 0; k < 16; k++) begin
         it = '0;
         it.row = 4'(k);
         it.req_type = psrbu_pkg::REQ_WR_NORM;
         it.value = $signed($urandom_range(0, 32'h01FFFFFF)) - 32'sh01000000;
         send_req(it, 1'b0, zr);
         it.req_type = psrbu_pkg::REQ_WR_BEL;
         it.value = $signed($urandom_range(0, 32'h00FFFFFF));
         send_req(it, 1'b0, zr);
      end

      // directed: extremes, every code, unused codes, zero normaliser, empty sums
      add_row(16, psrbu_pkg::REQ_WR_MAT, 3, 3, 15, 15, 32'h7FFFFFFF, 0, 1, zr);
      add_row(16, psrbu_pkg::REQ_WR_MAT, 0, 0, 0, 0, 32'h80000000, 0, 1, zr);
      add_row(16, psrbu_pkg::REQ_WR_NORM, 0, 0, 15, 0, 32'h01000000, 0, 1, zr);
      add_row(16, psrbu_pkg::REQ_WR_BEL, 0, 0, 0, 0, 32'h01000000, 0, 1, zr);
      add_row(16, 3'd5, 3, 3, 15, 15, 32'hFFFFFFFF, 24'hFFFFFF, 1, zr);
      add_row(16, 3'd6, 0, 0, 0, 0, 0, 0, 1, zr);
      add_row(16, 3'd7, 1, 2, 5, 10, 32'h12345678, 24'h5A5A5A, 1, zr);
      add_row(16, psrbu_pkg::REQ_UPDATE, 0, 0, 0, 0, 0, 0, 0, zr);
      add_row(2, psrbu_pkg::REQ_SAMPLE, 0, 0, 0, 0, 0, 24'h000000, 0, zr);
      add_row(2, psrbu_pkg::REQ_SAMPLE, 2, 0, 0, 0, 0, 24'hFFFFFF, 0, zr);
      add_row(2, psrbu_pkg::REQ_UPDATE, 1, 2, 0, 0, 0, 0, 0, zr);
      add_row(2, psrbu_pkg::REQ_UPDATE, 3, 3, 0, 0, 0, 0, 0, zr);
      add_row(1, psrbu_pkg::REQ_WR_NORM, 0, 0, 0, 0, 32'h00000000, 0, 1, zr);
      add_row(1, psrbu_pkg::REQ_UPDATE, 2, 1, 0, 0, 0, 0, 1, zn);
      add_row(1, psrbu_pkg::REQ_SAMPLE, 2, 0, 0, 0, 0, 24'h000000, 1, zr);
      add_row(1, psrbu_pkg::REQ_WR_NORM, 0, 0, 0, 0, 32'h01000000, 0, 1, zr);
      add_row(1, psrbu_pkg::REQ_WR_BEL, 0, 0, 0, 0, 32'h00800000, 0, 1, zr);
      add_row(1, psrbu_pkg::REQ_WR_MAT, 2, 1, 0, 0, 32'h02000000, 0, 1, zr);
      add_row(1, psrbu_pkg::REQ_UPDATE, 2, 1, 0, 0, 0, 0, 0, zr);
      add_row(0, psrbu_pkg::REQ_SAMPLE, 1, 0, 0, 0, 0, 24'h000000, 1, zr);
      add_row(0, psrbu_pkg::REQ_UPDATE, 1, 3, 0, 0, 0, 0, 1, zn);
      add_row(31, psrbu_pkg::REQ_UPDATE, 0, 0, 0, 0, 0, 0, 0, zr);

      foreach (stim_tab[i]) begin
         if (stim_tab[i].dim != dim_reg) write_dim(stim_tab[i].dim);
         send_req(stim_tab[i].item, stim_tab[i].has_exp, stim_tab[i].exp);
      end

      // random phases; each phase change drains the block first
      foreach (dim_list[p]) begin
         write_dim(dim_list[p]);
         for (int k = 0; k < 20; k++) send_req(rand_req(), 1'b0, zr);
      end

      drain();
      repeat (1500) @(posedge clock);
      $display("covered %0d results: %0d samples, %0d updates (%0d zero normaliser)",
               n_results, n_samples, n_updates, n_zero_norm);
      $display("active_dim settings 0, 1, 2, 16 and 31; %0d mismatches",
               error_count);
      if (error_count == 0 && result_q.size() == 0)
         $display("[psr_belief_update_sampler] OK");
      else
         $display("[psr_belief_update_sampler] ERROR");
      $finish;
   end

endmodule
